// ----- sv/wbh_pkg.sv -----
// ----------------------------------------------------------------------------
// wbh_pkg - white balance histogram shared definitions
// Payload types, command and status bundles, codes and arithmetic constants.
// ----------------------------------------------------------------------------
package wbh_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 17;
    localparam int COUNT_W   = 32;
    localparam int GAIN_FRAC = 14;
    localparam int PROD_W    = SAMPLE_W + GAIN_W;

    // round(0.333 * sum) = (sum * 333 + 500) / 1000
    localparam int SUM_W      = SAMPLE_W + 2;
    localparam int ACC_W      = 27;
    localparam int GRAY_MUL   = 333;
    localparam int GRAY_BIAS  = 500;
    // floor(x / 1000) = (x * DIV_RECIP) >> DIV_SHIFT, exact for x < 2**27
    localparam int DIV_RECIP  = 68719477;
    localparam int DIV_SHIFT  = 36;
    localparam int QUOT_W     = 2 * ACC_W;

    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    localparam logic [1:0] REG_GAIN_RED   = 2'd0;
    localparam logic [1:0] REG_GAIN_GREEN = 2'd1;
    localparam logic [1:0] REG_GAIN_BLUE  = 2'd2;
    localparam logic [1:0] REG_GRAY_MODE  = 2'd3;

    localparam logic [GAIN_W-1:0] GAIN_UNITY = 17'd16384;

    typedef struct packed {
        logic [1:0]          kind;
        logic [SAMPLE_W-1:0] red_in;
        logic [SAMPLE_W-1:0] green_in;
        logic [SAMPLE_W-1:0] blue_in;
        logic [1:0]          read_channel;
        logic [7:0]          read_bin;
    } pixel_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] red_out;
        logic [SAMPLE_W-1:0] green_out;
        logic [SAMPLE_W-1:0] blue_out;
        logic [COUNT_W-1:0]  bin_count;
        logic                count_valid;
    } result_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_GAIN,
        ST_SAT,
        ST_SUM,
        ST_DIV,
        ST_BIN,
        ST_READ,
        ST_WRITE,
        ST_CLEAR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic gain_en;
        logic sat_en;
        logic sum_en;
        logic div_en;
        logic bin_en;
        logic mem_rd;
        logic mem_wr;
        logic clr_wr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] in_kind;
        logic [1:0] kind;
        logic       clr_last;
    } status_t;

endpackage

// ----- sv/wbh_chan_if.sv -----
// ----------------------------------------------------------------------------
// wbh_chan_if - valid/ready channel
// Carries one payload per transfer from a source to a sink.
// ----------------------------------------------------------------------------
interface wbh_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/wbh_ctrl.sv -----
// ----------------------------------------------------------------------------
// wbh_ctrl - white balance histogram controller
// Sequences pixel, read and clear items and owns the result valid flag.
// ----------------------------------------------------------------------------
module wbh_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  wbh_pkg::status_t stat,
    output wbh_pkg::cmd_t    cmd
);
    import wbh_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (stat.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (stat.in_kind)
                        KIND_PIXEL: state_next = ST_GAIN;
                        KIND_CLEAR: state_next = ST_CLEAR;
                        KIND_READ:  state_next = ST_READ;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_GAIN:  state_next = ST_SAT;
            ST_SAT:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_DIV;
            ST_DIV:   state_next = ST_BIN;
            ST_BIN:   state_next = ST_READ;
            ST_READ:  state_next = (stat.kind == KIND_PIXEL) ? ST_WRITE : ST_DONE;
            ST_WRITE: state_next = ST_DONE;
            ST_CLEAR:
            begin
                if (stat.clr_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:  state_next = ST_INIT;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_INIT:  cmd.clr_wr   = 1'b1;
            ST_IDLE:  cmd.load_in  = in_valid;
            ST_GAIN:  cmd.gain_en  = 1'b1;
            ST_SAT:   cmd.sat_en   = 1'b1;
            ST_SUM:   cmd.sum_en   = 1'b1;
            ST_DIV:   cmd.div_en   = 1'b1;
            ST_BIN:   cmd.bin_en   = 1'b1;
            ST_READ:  cmd.mem_rd   = 1'b1;
            ST_WRITE: cmd.mem_wr   = 1'b1;
            ST_CLEAR: cmd.clr_wr   = 1'b1;
            ST_DONE:  cmd.out_load = out_free;
            default:  cmd = '0;
        endcase
    end

    // Set on load, drop once the waiting result is transferred.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.out_load)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- sv/wbh_datapath.sv -----
// ----------------------------------------------------------------------------
// wbh_datapath - white balance histogram datapath
// Gain, saturation, grayscale average, bin mapping and three histogram memories.
// ----------------------------------------------------------------------------
module wbh_datapath #(
    parameter int BIN_COUNT = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [wbh_pkg::GAIN_W-1:0]   cfg_data,
    input  wbh_pkg::pixel_t              in_data,
    input  wbh_pkg::cmd_t                cmd,
    output wbh_pkg::status_t             stat,
    output wbh_pkg::result_t             out_data
);
    import wbh_pkg::*;

    localparam int BIN_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;

    logic [GAIN_W-1:0]   gain_reg [3];
    logic                gray_mode_reg;

    pixel_t              in_reg;
    logic [PROD_W-1:0]   prod_reg [3];
    logic [SAMPLE_W-1:0] val_reg [3];
    logic [ACC_W-1:0]    acc_reg;
    logic [SAMPLE_W-1:0] gray_reg;
    logic [SAMPLE_W-1:0] final_reg [3];
    logic [BIN_W-1:0]    bin_reg [3];
    logic [BIN_W-1:0]    clr_cnt_reg;
    result_t             out_reg;

    logic [SAMPLE_W-1:0] sample [3];
    logic [SAMPLE_W-1:0] sat_val [3];
    logic [SAMPLE_W-1:0] final_val [3];
    logic [BIN_W-1:0]    bin_val [3];
    logic [COUNT_W-1:0]  rd_q [3];
    logic [SUM_W-1:0]    sum;
    logic [ACC_W-1:0]    acc_next;
    logic [QUOT_W-1:0]   quot;
    logic [23:0]         rd_wide;
    logic [BIN_W-1:0]    rd_addr;
    logic                rd_ok;
    logic                clr_last;
    result_t             res_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg[0]   <= GAIN_UNITY;
            gain_reg[1]   <= GAIN_UNITY;
            gain_reg[2]   <= GAIN_UNITY;
            gray_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN_RED:   gain_reg[0]   <= cfg_data;
                REG_GAIN_GREEN: gain_reg[1]   <= cfg_data;
                REG_GAIN_BLUE:  gain_reg[2]   <= cfg_data;
                REG_GRAY_MODE:  gray_mode_reg <= cfg_data[0];
            endcase
        end
    end

    assign sample[0] = in_reg.red_in;
    assign sample[1] = in_reg.green_in;
    assign sample[2] = in_reg.blue_in;

    // Per-channel gain, round half up, saturate, bin mapping
    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        logic [PROD_W:0]     rnd;
        logic [PROD_W-GAIN_FRAC:0] shifted;
        logic [2*GAIN_W-2:0] bin_prod;

        assign rnd     = {1'b0, prod_reg[c]} + (PROD_W + 1)'(1 << (GAIN_FRAC - 1));
        assign shifted = rnd[PROD_W:GAIN_FRAC];
        assign sat_val[c] = (|shifted[PROD_W-GAIN_FRAC:SAMPLE_W]) ?
                            {SAMPLE_W{1'b1}} : shifted[SAMPLE_W-1:0];
        assign final_val[c] = gray_mode_reg ? gray_reg : val_reg[c];
        assign bin_prod     = (2*GAIN_W-1)'(final_val[c]) * (2*GAIN_W-1)'(BIN_COUNT);
        assign bin_val[c]   = bin_prod[SAMPLE_W +: BIN_W];
    end

    assign sum      = SUM_W'(val_reg[0]) + SUM_W'(val_reg[1]) + SUM_W'(val_reg[2]);
    assign acc_next = ACC_W'(sum) * ACC_W'(GRAY_MUL) + ACC_W'(GRAY_BIAS);
    assign quot     = QUOT_W'(acc_reg) * QUOT_W'(DIV_RECIP);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            in_reg <= in_data;
        for (int c = 0; c < 3; c++)
        begin
            if (cmd.gain_en)
                prod_reg[c] <= PROD_W'(sample[c]) * PROD_W'(gain_reg[c]);
            if (cmd.sat_en)
                val_reg[c] <= sat_val[c];
            if (cmd.bin_en)
            begin
                final_reg[c] <= final_val[c];
                bin_reg[c]   <= bin_val[c];
            end
        end
        if (cmd.sum_en)
            acc_reg <= acc_next;
        if (cmd.div_en)
            gray_reg <= quot[DIV_SHIFT +: SAMPLE_W];
        if (cmd.out_load)
            out_reg <= res_next;
    end

    // Clearing sweep, shared by reset and clear items
    assign clr_last = (clr_cnt_reg == BIN_W'(BIN_COUNT - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clr_wr)
            clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + 1'b1;
    end

    assign rd_wide = 24'(in_reg.read_bin);
    assign rd_addr = rd_wide[BIN_W-1:0];
    assign rd_ok   = (in_reg.read_channel == CH_RED || in_reg.read_channel == CH_GREEN ||
                      in_reg.read_channel == CH_BLUE) &&
                     (17'(in_reg.read_bin) < 17'(BIN_COUNT));

    // One histogram memory per channel
    for (genvar c = 0; c < 3; c++)
    begin : g_hist
        logic [COUNT_W-1:0] mem [BIN_COUNT];
        logic [COUNT_W-1:0] rd_reg;
        logic [COUNT_W-1:0] inc;
        logic [BIN_W-1:0]   addr;

        assign addr = (in_reg.kind == KIND_PIXEL) ? bin_reg[c] : rd_addr;
        // hold the counter at full scale
        assign inc  = (&rd_reg) ? rd_reg : rd_reg + 1'b1;
        assign rd_q[c] = rd_reg;

        always_ff @(posedge clk)
        begin
            if (cmd.clr_wr)
                mem[clr_cnt_reg] <= '0;
            else if (cmd.mem_wr)
                mem[bin_reg[c]] <= inc;
            if (cmd.mem_rd)
                rd_reg <= mem[addr];
        end
    end

    always_comb
    begin
        res_next = '0;
        case (in_reg.kind)
            KIND_PIXEL:
            begin
                res_next.red_out   = final_reg[0];
                res_next.green_out = final_reg[1];
                res_next.blue_out  = final_reg[2];
            end
            KIND_READ:
            begin
                if (rd_ok)
                begin
                    res_next.count_valid = 1'b1;
                    case (in_reg.read_channel)
                        CH_RED:   res_next.bin_count = rd_q[0];
                        CH_GREEN: res_next.bin_count = rd_q[1];
                        default:  res_next.bin_count = rd_q[2];
                    endcase
                end
            end
            default: res_next = '0;
        endcase
    end

    assign out_data       = out_reg;
    assign stat.in_kind   = in_data.kind;
    assign stat.kind      = in_reg.kind;
    assign stat.clr_last  = clr_last;

endmodule

// ----- sv/white_balance_histogram_core.sv -----
// ----------------------------------------------------------------------------
// white_balance_histogram_core - white balance with channel histograms
// Applies per-channel gains, optional grayscale, and counts values per channel.
//
//   Port     Dir   Handshake       Payload
//   pixel    in    valid/ready     wbh_pkg::pixel_t  (pixel, clear or bin read)
//   result   out   valid/ready     wbh_pkg::result_t (one result per item)
//   cfg_*    in    write enable    register index and data, no read-back
//
// A pixel passes from transfer to result through gain, saturate, sum,
// divide, bin, histogram read and write, and load; a bin read goes through
// histogram read and load, kind three straight to load, and a clear sweeps
// one bin per cycle in all three histogram memories. After reset a clearing
// pass over all BIN_COUNT bins runs before the first item is taken. The next
// item is taken while a result waits; a stalled result holds the block in its final step.
// ----------------------------------------------------------------------------
module white_balance_histogram_core #(
    parameter int BIN_COUNT = 256
) (
    input  logic                        clk,
    input  logic                        rst_n,
    wbh_chan_if.sink                    pixel,
    wbh_chan_if.source                  result,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [wbh_pkg::GAIN_W-1:0]  cfg_data
);
    import wbh_pkg::*;

    cmd_t    cmd;
    status_t stat;
    result_t res_data;

    wbh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    wbh_datapath #(
        .BIN_COUNT (BIN_COUNT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (pixel.data),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (res_data)
    );

    assign result.data = res_data;

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!result.valid || result.ready))
        else $error("result register loaded while a result waits");

    // Every histogram update follows a read of the same counter.
    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> $past(cmd.mem_rd))
        else $error("histogram write without preceding read");

    // No item is taken during a clearing pass.
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_wr |-> !(pixel.valid && pixel.ready))
        else $error("item taken during clearing pass");

    // Clearing and counting never write the memories together.
    a_single_writer: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_wr |-> !cmd.clr_wr)
        else $error("histogram written by clear and update at once");

endmodule

// ----- tb/white_balance_histogram_core_tb.sv -----
// ----------------------------------------------------------------------------
// white_balance_histogram_core_tb - self-checking bench for the balance core
// Walks a short directed table, then random pixel, clear and bin-read
// traffic over several gain and grayscale settings. Each result is checked
// against a local gain/grayscale/histogram predictor, with random idle
// cycles on both channels.
// ----------------------------------------------------------------------------
module white_balance_histogram_core_tb;

    import wbh_pkg::*;

    localparam int          BINS       = 256;
    localparam int          BATCH      = 100;
    localparam int          PHASES     = 12;
    localparam logic [1:0]  KIND_NONE  = 2'd3;
    localparam logic [1:0]  CH_NONE    = 2'd3;
    localparam result_t     NO_RESULT  = '0;

    typedef struct {
        pixel_t  item;
        bit      typed;
        result_t want;
    } stim_row_t;

    typedef struct {
        bit      typed;
        result_t want;
    } fixed_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [GAIN_W-1:0] cfg_data;

    wbh_chan_if #(.payload_t(pixel_t))  pixel_if ();
    wbh_chan_if #(.payload_t(result_t)) result_if ();

    white_balance_histogram_core #(.BIN_COUNT(BINS)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel_if.sink),
        .result    (result_if.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // predictor state
    logic [GAIN_W-1:0]  gain_r = GAIN_UNITY;
    logic [GAIN_W-1:0]  gain_g = GAIN_UNITY;
    logic [GAIN_W-1:0]  gain_b = GAIN_UNITY;
    logic               gray_on = 1'b0;
    logic [COUNT_W-1:0] hist [0:2][0:BINS-1];
    logic [7:0]         last_bin [0:2];

    result_t       pending_results [$];
    fixed_result_t fixed_q [$];
    stim_row_t     dir_rows [$];

    int  n_sent = 0;
    int  n_got = 0;
    int  mismatches = 0;
    bit  no_idle = 1'b0;

    initial
    begin
        foreach (hist[c, b])
            hist[c][b] = '0;
        foreach (last_bin[c])
            last_bin[c] = '0;
    end

    function automatic logic [SAMPLE_W-1:0] scaled(logic [SAMPLE_W-1:0] s,
                                                   logic [GAIN_W-1:0] gain);
        longint unsigned p;
        p = 64'(s);
        p = (p * 64'(gain) + 64'd8192) >> GAIN_FRAC;
        return (p > 64'd65535) ? 16'hFFFF : p[SAMPLE_W-1:0];
    endfunction

    function automatic void count_value(int ch, logic [SAMPLE_W-1:0] v);
        longint unsigned bin;
        bin = 64'(v);
        bin = (bin * 64'(BINS)) / 64'd65536;
        if (bin >= 64'(BINS))
            bin = 64'(BINS - 1);
        last_bin[ch] = bin[7:0];
        if (hist[ch][bin] != 32'hFFFF_FFFF)
            hist[ch][bin] = hist[ch][bin] + 1;
    endfunction

    // gain, optional grayscale, histogram update
    function automatic result_t balance_item(pixel_t it);
        result_t         res;
        logic [15:0]     r, g, b;
        longint unsigned acc;
        res = NO_RESULT;
        case (it.kind)
            KIND_PIXEL:
            begin
                r = scaled(it.red_in, gain_r);
                g = scaled(it.green_in, gain_g);
                b = scaled(it.blue_in, gain_b);
                if (gray_on)
                begin
                    acc = 64'(r);
                    acc = acc + 64'(g) + 64'(b);
                    acc = (acc * 64'(GRAY_MUL) + 64'(GRAY_BIAS)) / 64'd1000;
                    if (acc > 64'd65535)
                        acc = 64'd65535;
                    r = acc[15:0];
                    g = acc[15:0];
                    b = acc[15:0];
                end
                count_value(0, r);
                count_value(1, g);
                count_value(2, b);
                res.red_out   = r;
                res.green_out = g;
                res.blue_out  = b;
            end
            KIND_CLEAR:
            begin
                foreach (hist[c, k])
                    hist[c][k] = '0;
            end
            KIND_READ:
            begin
                if (it.read_channel <= CH_BLUE && 32'(it.read_bin) < BINS)
                begin
                    res.bin_count   = hist[it.read_channel][it.read_bin];
                    res.count_valid = 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic pixel_t mk_item(logic [1:0] k, logic [15:0] r, logic [15:0] g,
                                       logic [15:0] b, logic [1:0] ch, logic [7:0] bin);
        pixel_t it;
        it.kind         = k;
        it.red_in       = r;
        it.green_in     = g;
        it.blue_in      = b;
        it.read_channel = ch;
        it.read_bin     = bin;
        return it;
    endfunction

    function automatic result_t pix_res(logic [15:0] r, logic [15:0] g, logic [15:0] b);
        return '{r, g, b, 32'd0, 1'b0};
    endfunction

    function automatic result_t count_res(logic [31:0] c);
        return '{16'd0, 16'd0, 16'd0, c, 1'b1};
    endfunction

    function automatic void add_row(pixel_t it, bit typed, result_t want);
        dir_rows.push_back('{it, typed, want});
    endfunction

    function automatic pixel_t random_item();
        pixel_t it;
        int     pick;
        int     ch;
        it.red_in       = 16'($urandom);
        it.green_in     = 16'($urandom);
        it.blue_in      = 16'($urandom);
        it.read_channel = 2'($urandom_range(0, 3));
        it.read_bin     = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            it.kind = KIND_PIXEL;
            case ($urandom_range(0, 7))
                0:
                begin
                    // channels summing to 500: half-up tie in the grayscale average
                    it.red_in   = 16'($urandom_range(0, 500));
                    it.green_in = 16'($urandom_range(0, 500 - it.red_in));
                    it.blue_in  = 16'(500 - it.red_in - it.green_in);
                end
                1:
                begin
                    it.red_in   = ($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
                    it.green_in = ($urandom_range(0, 1) ? 16'h8000 : 16'h7FFF);
                    it.blue_in  = ($urandom_range(0, 1) ? 16'hFFFF : 16'h0001);
                end
                2, 3:
                begin
                    it.red_in   = it.red_in >> $urandom_range(0, 12);
                    it.green_in = it.green_in >> $urandom_range(0, 12);
                    it.blue_in  = it.blue_in >> $urandom_range(0, 12);
                end
                default: ;
            endcase
        end
        else if (pick < 92)
        begin
            it.kind = KIND_READ;
            ch = $urandom_range(0, 9);
            it.read_channel = (ch < 3) ? ch[1:0] :
                              (ch == 9) ? CH_NONE : 2'($urandom_range(0, 2));
            // aim half the reads at a bin that was hit recently
            if (it.read_channel <= CH_BLUE && $urandom_range(0, 1))
                it.read_bin = last_bin[it.read_channel];
        end
        else if (pick < 95)
            it.kind = KIND_CLEAR;
        else
            it.kind = KIND_NONE;
        return it;
    endfunction

    task automatic send_item(pixel_t it, bit typed, result_t want);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        fixed_q.push_back('{typed, want});
        if (gap > 0)
        begin
            pixel_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_if.valid <= 1'b1;
        pixel_if.data  <= it;
        do
            @(posedge clk);
        while (!pixel_if.ready);
        n_sent++;
    endtask

    task automatic drain();
        pixel_if.valid <= 1'b0;
        while (n_got < n_sent)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [GAIN_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_GAIN_RED:   gain_r = val;
            REG_GAIN_GREEN: gain_g = val;
            REG_GAIN_BLUE:  gain_b = val;
            REG_GRAY_MODE:  gray_on = val[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [GAIN_W-1:0] r, logic [GAIN_W-1:0] g,
                                  logic [GAIN_W-1:0] b, logic gray);
        write_reg(REG_GAIN_RED, r);
        write_reg(REG_GAIN_GREEN, g);
        write_reg(REG_GAIN_BLUE, b);
        write_reg(REG_GRAY_MODE, {{(GAIN_W-1){1'b0}}, gray});
        cfg_we <= 1'b0;
    endtask

    // record every accepted item and its expected result
    always @(posedge clk)
    begin
        fixed_result_t fr;
        result_t       pred;
        if (rst_n && pixel_if.valid && pixel_if.ready)
        begin
            fr   = fixed_q.pop_front();
            pred = balance_item(pixel_if.data);
            pending_results.push_back(fr.typed ? fr.want : pred);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got = result_if.data;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: expected none, got %h", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.red_out !== want.red_out || got.green_out !== want.green_out ||
                    got.blue_out !== want.blue_out || got.bin_count !== want.bin_count ||
                    got.count_valid !== want.count_valid)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected rgb %h %h %h count %h/%b, got %h %h %h %h/%b",
                                 n_got, want.red_out, want.green_out, want.blue_out,
                                 want.bin_count, want.count_valid, got.red_out,
                                 got.green_out, got.blue_out, got.bin_count,
                                 got.count_valid);
                end
            end
            n_got++;
        end
    end

    // result sink with random stalls
    initial
    begin
        int stall;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_if.valid);
        end
    end

    initial
    begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        logic [GAIN_W-1:0] gr, gg, gb;
        logic              gm;
        pixel_t            it;

        pixel_if.valid <= 1'b0;
        pixel_if.data  <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_GAIN_RED;
        cfg_data       <= '0;

        // directed table at reset settings: unity gains, grayscale off
        add_row(mk_item(KIND_READ, 16'h0, 16'h0, 16'h0, CH_RED, 8'd0), 1, count_res(0));
        add_row(mk_item(KIND_READ, 16'h0, 16'h0, 16'h0, CH_BLUE, 8'd255), 1, count_res(0));
        add_row(mk_item(KIND_PIXEL, 16'h0, 16'h0, 16'h0, CH_RED, 8'd0), 1,
                pix_res(16'h0, 16'h0, 16'h0));
        add_row(mk_item(KIND_PIXEL, 16'hFFFF, 16'hFFFF, 16'hFFFF, CH_NONE, 8'hFF), 1,
                pix_res(16'hFFFF, 16'hFFFF, 16'hFFFF));
        add_row(mk_item(KIND_PIXEL, 16'hFFFF, 16'h0, 16'hFFFF, CH_RED, 8'd0), 1,
                pix_res(16'hFFFF, 16'h0, 16'hFFFF));
        add_row(mk_item(KIND_READ, 16'h0, 16'h0, 16'h0, CH_RED, 8'd0), 1, count_res(1));
        add_row(mk_item(KIND_READ, 16'h0, 16'h0, 16'h0, CH_RED, 8'd255), 1, count_res(2));
        add_row(mk_item(KIND_READ, 16'h0, 16'h0, 16'h0, CH_GREEN, 8'd0), 1, count_res(2));
        add_row(mk_item(KIND_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, CH_NONE, 8'd0), 1, NO_RESULT);
        add_row(mk_item(KIND_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, CH_NONE, 8'hFF), 1, NO_RESULT);
        add_row(mk_item(KIND_PIXEL, 16'h00FF, 16'h0100, 16'h8001, CH_RED, 8'd0), 0, NO_RESULT);
        add_row(mk_item(KIND_PIXEL, 16'h5555, 16'hAAAA, 16'h1234, CH_RED, 8'd0), 0, NO_RESULT);
        add_row(mk_item(KIND_READ, 16'h0, 16'h0, 16'h0, CH_GREEN, 8'hAA), 0, NO_RESULT);
        add_row(mk_item(KIND_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, CH_NONE, 8'hFF), 1, NO_RESULT);
        add_row(mk_item(KIND_READ, 16'h0, 16'h0, 16'h0, CH_RED, 8'd255), 1, count_res(0));
        add_row(mk_item(KIND_READ, 16'h0, 16'h0, 16'h0, CH_GREEN, 8'd0), 1, count_res(0));
        add_row(mk_item(KIND_PIXEL, 16'h7FFF, 16'h8000, 16'h0001, CH_RED, 8'd0), 0, NO_RESULT);
        add_row(mk_item(KIND_READ, 16'h0, 16'h0, 16'h0, CH_BLUE, 8'd0), 1, count_res(1));
        add_row(mk_item(KIND_READ, 16'h0, 16'h0, 16'h0, CH_GREEN, 8'h80), 0, NO_RESULT);
        add_row(mk_item(KIND_READ, 16'h0, 16'h0, 16'h0, CH_RED, 8'h7F), 0, NO_RESULT);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        drain();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    gr = 17'd0;      gg = 17'd0;      gb = 17'd0;      gm = 1'b0;
                end
                1:
                begin
                    gr = 17'd131071; gg = 17'd131071; gb = 17'd131071; gm = 1'b1;
                end
                2:
                begin
                    gr = 17'd65536;  gg = 17'd16384;  gb = 17'd0;      gm = 1'b1;
                end
                3:
                begin
                    gr = 17'd8192;   gg = 17'd8192;   gb = 17'd24576;  gm = 1'b0;
                end
                4:
                begin
                    gr = 17'd16384;  gg = 17'd16384;  gb = 17'd16384;  gm = 1'b1;
                end
                5:
                begin
                    gr = 17'd1;      gg = 17'd65535;  gb = 17'd98304;  gm = 1'b0;
                end
                default:
                begin
                    gr = GAIN_W'($urandom_range(0, 131071));
                    gg = GAIN_W'($urandom_range(0, 65536));
                    gb = GAIN_W'($urandom_range(0, 131071));
                    gm = 1'($urandom_range(0, 1));
                end
            endcase
            apply_settings(gr, gg, gb, gm);
            no_idle = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < BATCH; n++)
            begin
                // hold the sender until the block has emptied out
                if (n == BATCH / 2 && (ph == 0 || $urandom_range(0, 2) == 0))
                    drain();
                if (n == BATCH / 4)
                    no_idle = ($urandom_range(0, 3) == 0);
                it = random_item();
                send_item(it, 0, NO_RESULT);
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            mismatches++;
            $display("%0d expected results never arrived", pending_results.size());
        end
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
